FILE: rtl/smf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the sliding window median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 7;

  typedef logic signed [DATA_W-1:0] sample_t;

  // Per-cell control from the top level for one transfer.
  typedef struct packed {
    logic load;       // a sample transfers this cycle
    logic can_evict;  // window is full and this cell lies inside it
    logic shift;      // the evicted cell sits at or below this one
    logic kept;       // after eviction this position still holds a sample
  } cell_ctrl_t;

endpackage : smf_pkg
`default_nettype wire

FILE: rtl/smf_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_sample_if
// Valid/ready channel that carries one input sample.
// ----------------------------------------------------------------------------
interface smf_sample_if
  import smf_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface : smf_sample_if
`default_nettype wire

FILE: rtl/smf_median_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_median_if
// Valid/ready channel that carries one median result.
// ----------------------------------------------------------------------------
interface smf_median_if
  import smf_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t median_value;

  modport source (output valid, output median_value, input ready);
  modport sink   (input valid, input median_value, output ready);
endinterface : smf_median_if
`default_nettype wire

FILE: rtl/sliding_window_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median
// Lower median over the last window_len signed samples of a stream.
// ----------------------------------------------------------------------------
// The window lives in a row of MAX_WINDOW cells kept in ascending order; each
// cell holds a sample and its age in samples. A transfer on the sample channel
// updates the whole row at once: the cell whose age reaches window_len-1
// drops out (only once the window is full), the cells above it move down one
// place, and the new sample slides in at its sorted position while larger
// entries move up. No result appears until window_len samples have arrived;
// from then on every sample yields the element at rank ceil(n/2). The median
// is read from the row in the cycle after the update. The result waits in an
// output register; a new sample is taken once no median read is pending and
// that register is free or is being drained. Writing window_len (0 reads as
// 1, values above MAX_WINDOW saturate) empties the window; write it only
// while idle.
// ----------------------------------------------------------------------------
module sliding_window_median
  import smf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  smf_sample_if.sink          sample_i,
  smf_median_if.source        median_o,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AgeW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);

  // Window length, fill count and control flags.
  logic [CntW-1:0] win_len_q, win_len_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  sample_t         median_q, median_d;

  logic            accept;
  logic            full;
  logic [CntW-1:0] kept_cnt;
  logic [CntW-1:0] fill_next;
  logic [AgeW-1:0] evict_age;
  logic [AgeW-1:0] med_idx;

  // Cell row wiring.
  sample_t         cell_val  [MAX_WINDOW];
  logic [AgeW-1:0] cell_age  [MAX_WINDOW];
  logic            cell_le   [MAX_WINDOW];
  sample_t         cell_rval [MAX_WINDOW];
  logic [AgeW-1:0] cell_rage [MAX_WINDOW];
  logic            cell_g    [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] evict_vec;
  cell_ctrl_t      cell_ctrl [MAX_WINDOW];

  // Take a sample only when no median read is pending and the output slot
  // is free or transfers now.
  assign sample_i.ready = !pend_q && (!out_valid_q || median_o.ready);
  assign accept         = sample_i.valid && sample_i.ready;

  assign full      = (fill_q == win_len_q);
  assign kept_cnt  = full ? (win_len_q - CntW'(1)) : fill_q;
  assign fill_next = full ? win_len_q : (fill_q + CntW'(1));
  assign evict_age = AgeW'(win_len_q - CntW'(1));
  assign med_idx   = AgeW'((win_len_q - CntW'(1)) >> 1);

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    localparam logic [MAX_WINDOW-1:0] LowMask = {MAX_WINDOW{1'b1}} >> (MAX_WINDOW - 1 - i);

    sample_t         right_val;
    logic [AgeW-1:0] right_age;
    logic            right_le;
    sample_t         left_rval;
    logic [AgeW-1:0] left_rage;
    logic            left_g;

    assign cell_ctrl[i].load      = accept;
    assign cell_ctrl[i].can_evict = full && (CntW'(i) < win_len_q);
    assign cell_ctrl[i].shift     = |(evict_vec & LowMask);
    assign cell_ctrl[i].kept      = (CntW'(i) < kept_cnt);

    if (i == MAX_WINDOW - 1) begin : g_top_end
      // Nothing lives above the last cell.
      assign right_val = '0;
      assign right_age = '0;
      assign right_le  = 1'b0;
    end else begin : g_top_mid
      assign right_val = cell_val[i+1];
      assign right_age = cell_age[i+1];
      assign right_le  = cell_le[i+1];
    end

    if (i == 0) begin : g_bot_end
      // The bottom cell takes the new sample unless it keeps its own.
      assign left_rval = '0;
      assign left_rage = '0;
      assign left_g    = 1'b1;
    end else begin : g_bot_mid
      assign left_rval = cell_rval[i-1];
      assign left_rage = cell_rage[i-1];
      assign left_g    = cell_g[i-1];
    end

    smf_cell #(
      .AgeW (AgeW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .sample_i    (sample_i.sample),
      .evict_age_i (evict_age),
      .right_val_i (right_val),
      .right_age_i (right_age),
      .right_le_i  (right_le),
      .left_rval_i (left_rval),
      .left_rage_i (left_rage),
      .left_g_i    (left_g),
      .val_o       (cell_val[i]),
      .age_o       (cell_age[i]),
      .le_o        (cell_le[i]),
      .evict_o     (evict_vec[i]),
      .rval_o      (cell_rval[i]),
      .rage_o      (cell_rage[i]),
      .g_o         (cell_g[i])
    );
  end

  // Window length, fill count and pending median read.
  always_comb begin
    win_len_d = win_len_q;
    fill_d    = fill_q;
    pend_d    = 1'b0;
    if (cfg_we_i) begin
      // Clamp the length into 1..MAX_WINDOW and empty the window.
      if (cfg_wdata_i == '0) begin
        win_len_d = CntW'(1);
      end else if (32'(cfg_wdata_i) > MAX_WINDOW) begin
        win_len_d = CntW'(MAX_WINDOW);
      end else begin
        win_len_d = CntW'(cfg_wdata_i);
      end
      fill_d = '0;
    end else if (accept) begin
      fill_d = fill_next;
      pend_d = (fill_next == win_len_q);
    end
  end

  // Output register: load the median the cycle after the row update, drop
  // it once it transfers.
  always_comb begin
    out_valid_d = out_valid_q;
    median_d    = median_q;
    if (pend_q) begin
      out_valid_d = 1'b1;
      median_d    = cell_val[med_idx];
    end else if (median_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= CntW'(1);
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_len_q   <= win_len_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    median_q <= median_d;
  end

  assign median_o.valid        = out_valid_q;
  assign median_o.median_value = median_q;

endmodule : sliding_window_median
`default_nettype wire

FILE: rtl/smf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_cell
// One position of the sorted window: holds a sample and its age, drops the
// oldest entry and opens a slot for the new sample together with neighbors.
// ----------------------------------------------------------------------------
module smf_cell
  import smf_pkg::*;
#(
  parameter int unsigned AgeW = 6
) (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  sample_t         sample_i,
  input  logic [AgeW-1:0] evict_age_i,
  input  sample_t         right_val_i,
  input  logic [AgeW-1:0] right_age_i,
  input  logic            right_le_i,
  input  sample_t         left_rval_i,
  input  logic [AgeW-1:0] left_rage_i,
  input  logic            left_g_i,
  output sample_t         val_o,
  output logic [AgeW-1:0] age_o,
  output logic            le_o,
  output logic            evict_o,
  output sample_t         rval_o,
  output logic [AgeW-1:0] rage_o,
  output logic            g_o
);

  sample_t         val_q, val_d;
  logic [AgeW-1:0] age_q, age_d;
  logic            r_le;

  assign le_o    = (val_q <= sample_i);
  assign evict_o = ctrl_i.can_evict && (age_q == evict_age_i);

  // Close the gap left by the evicted entry.
  assign rval_o = ctrl_i.shift ? right_val_i : val_q;
  assign rage_o = ctrl_i.shift ? right_age_i : age_q;
  assign r_le   = ctrl_i.shift ? right_le_i  : le_o;
  assign g_o    = ctrl_i.kept && r_le;

  always_comb begin
    val_d = val_q;
    age_d = age_q;
    if (ctrl_i.load) begin
      if (g_o) begin
        val_d = rval_o;
        age_d = rage_o + AgeW'(1);
      end else if (left_g_i) begin
        val_d = sample_i;
        age_d = '0;
      end else begin
        val_d = left_rval_i;
        age_d = left_rage_i + AgeW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule : smf_cell
`default_nettype wire

FILE: sim/sliding_window_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_checker
// Watches both channels and the window length port of the median filter,
// predicts the lower median of every full window and compares each result.
// ----------------------------------------------------------------------------
module sliding_window_median_checker
  import smf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  smf_sample_if            sample_bus,
  smf_median_if            median_bus,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int unsigned      outstanding_o,
  output int unsigned      fail_count_o
);

  // Window contents in arrival order and in ascending order.
  sample_t     arrivals[$];
  sample_t     ranked[$];
  sample_t     expected_medians[$];
  sample_t     want;
  int unsigned span = 1;

  // Slide one sample into the window; queue the median once the window is full.
  task automatic slide_window(input sample_t value);
    int unsigned pos;
    sample_t     oldest;
    if (arrivals.size() == span) begin
      oldest = arrivals.pop_front();
      pos = 0;
      while (pos < ranked.size() && ranked[pos] != oldest) pos++;
      ranked.delete(pos);
    end
    pos = 0;
    while (pos < ranked.size() && ranked[pos] <= value) pos++;
    ranked.insert(pos, value);
    arrivals.push_back(value);
    if (arrivals.size() == span) begin
      expected_medians.push_back(ranked[(span + 1) / 2 - 1]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span = 1;
      arrivals.delete();
      ranked.delete();
      expected_medians.delete();
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      // Retire results first: a result never belongs to a sample of this edge.
      if (median_bus.valid && median_bus.ready) begin
        if (expected_medians.size() == 0) begin
          $display("%0t: unexpected median, expected none, got %0d",
                   $time, median_bus.median_value);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_medians.pop_front();
          if (median_bus.median_value !== want) begin
            $display("%0t: median mismatch, expected %0d, got %0d",
                     $time, want, median_bus.median_value);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // Clamp the new length and empty the window.
      if (cfg_we_i) begin
        if (cfg_wdata_i == 0) begin
          span = 1;
        end else if (cfg_wdata_i > MAX_WINDOW) begin
          span = MAX_WINDOW;
        end else begin
          span = 32'(cfg_wdata_i);
        end
        arrivals.delete();
        ranked.delete();
      end
      if (sample_bus.valid && sample_bus.ready) begin
        slide_window(sample_bus.sample);
      end
      outstanding_o <= expected_medians.size();
    end
  end

endmodule : sliding_window_median_checker

FILE: sim/sliding_window_median_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Stimulus and verdict for the sliding window median filter.
// ----------------------------------------------------------------------------
// A directed run covers the sample extremes, a window length of zero, odd and
// even windows and duplicate eviction. Random phases then set a new window
// length each (saturating and extreme values among them) and stream samples
// with random gaps on both channels. One phase holds the result channel off
// long enough to fill the block and stall its input. The checker instance
// predicts and compares; this module only drives and reports.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
  import smf_pkg::*;

  localparam int unsigned MAX_WINDOW   = 64;
  localparam int unsigned ITEM_TARGET  = 1650;
  localparam int unsigned RESULT_STALL = 150;     // long hold-off of the receiver
  localparam int unsigned DRAIN_CYCLES = 8;       // row update plus median read, with margin
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam sample_t     SAMPLE_MAX   = sample_t'(32'h7FFF_FFFF);
  localparam sample_t     SAMPLE_MIN   = sample_t'(32'h8000_0000);

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned stalls_asked;
  int unsigned stalls_done;
  int unsigned phase;
  int unsigned burst;
  logic [CFG_W-1:0] next_len;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  smf_sample_if sample_bus ();
  smf_median_if median_bus ();

  sliding_window_median #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_bus),
    .median_o    (median_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  sliding_window_median_checker #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_bus    (sample_bus),
    .median_bus    (median_bus),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always #1 clk_i = ~clk_i;

  // Pick a sample: mostly full range, often a narrow band so duplicates
  // pile up in the window, now and then a signed extreme.
  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4: return sample_t'(int'($urandom_range(6)) - 3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until the transfer; maybe idle first.
  // Leave valid high afterwards so back-to-back samples need no toggle.
  task automatic send_sample(input sample_t value);
    if (tx_idle_on && $urandom_range(99) < 20) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= value;
    do begin
      @(posedge clk_i);
    end while (!sample_bus.ready);
    items_sent++;
  endtask

  // Drop valid and wait for every predicted median, then let the block settle:
  // a sample that gives no result may still be in flight.
  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the window length while the block is idle.
  task automatic write_window(input logic [CFG_W-1:0] len);
    wait_drained();
    cfg_wdata <= len;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    median_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stalls_asked != stalls_done) begin
        stalls_done++;
        median_bus.ready <= 1'b0;
        repeat (RESULT_STALL) @(posedge clk_i);
      end else begin
        median_bus.ready <= !rx_idle_on || ($urandom_range(99) >= 20);
      end
    end
  end

  // Watchdog: end the run if it stops making progress.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    sample_bus.valid  <= 1'b0;
    sample_bus.sample <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    items_sent   = 0;
    stalls_asked = 0;
    stalls_done  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length is one: every sample is its own median.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));

    // Length zero reads as one.
    write_window(7'd0);
    send_sample(sample_t'(1));
    send_sample(sample_t'(2));

    // Odd window with duplicates: evict one copy of a repeated value.
    write_window(7'd3);
    send_sample(sample_t'(5));
    send_sample(sample_t'(5));
    send_sample(sample_t'(-7));
    send_sample(sample_t'(5));
    send_sample(sample_t'(5));
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);

    // Even window: lower of the two middle entries.
    write_window(7'd2);
    send_sample(sample_t'(10));
    send_sample(sample_t'(-10));
    send_sample(sample_t'(3));
    send_sample(sample_t'(3));

    // Hold results off while samples keep coming, so the block backs up,
    // then pause until every result is back.
    write_window(7'd4);
    stalls_asked <= stalls_asked + 1;
    repeat (40) send_sample(random_sample());

    // Random phases, each with a fresh window length.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      if (phase == 1) begin
        next_len = 7'd127;
      end else if (phase == 2) begin
        next_len = CFG_W'(MAX_WINDOW);
      end else begin
        case ($urandom_range(9))
          0: next_len = 7'd0;
          1: next_len = 7'd1;
          2: next_len = CFG_W'(MAX_WINDOW);
          3: next_len = CFG_W'(MAX_WINDOW + 1);
          4: next_len = 7'd127;
          default: next_len = CFG_W'($urandom_range(9, 2));
        endcase
      end
      // Run a few phases with no idling on either side.
      tx_idle_on  = !(phase >= 6 && phase <= 9);
      rx_idle_on <= !(phase >= 6 && phase <= 9);
      write_window(next_len);
      burst = (next_len == 0) ? 1 : (next_len > MAX_WINDOW) ? MAX_WINDOW : next_len;
      burst += $urandom_range(40, 4);
      repeat (burst) send_sample(random_sample());
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule : sliding_window_median_tb
